// File: design/iiad_pkg.sv
// Shared types, codes and helpers of the indexed item array decoder.
`default_nettype none
package iiad_pkg;

  // Result kinds as carried on the master-side tuser.
  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_DESC   = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_ERROR  = 3'd3,
    KIND_DONE   = 3'd4
  } kind_e;

  // Error codes reported with an error result.
  typedef enum logic [1:0] {
    ERR_TRUNC  = 2'd0,
    ERR_TAG    = 2'd1,
    ERR_COUNT  = 2'd2,
    ERR_OFFSET = 2'd3
  } err_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_FORMAT_TAG = 1'b0,
    CFG_MIN_SIZE   = 1'b1
  } cfg_idx_e;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  item_index;
    logic [31:0] item_id;
    logic [31:0] word;
    logic [23:0] length;
    logic [7:0]  payload_byte;
    logic        last_of_item;
    err_e        error_code;
  } result_t;

  localparam int HDR_BYTES   = 16;
  localparam int MIN_FLOOR   = 16;
  localparam int OUT_TDATA_W = 112;
  localparam int IN_TDATA_W  = 32;

  // Builds a result from the given field values.
  function automatic result_t make_result(kind_e kind, logic [7:0] idx, logic [31:0] id,
                                          logic [31:0] word, logic [23:0] len,
                                          logic [7:0] pay, logic lst, err_e err);
    result_t r;
    r.kind         = kind;
    r.item_index   = idx;
    r.item_id      = id;
    r.word         = word;
    r.length       = len;
    r.payload_byte = pay;
    r.last_of_item = lst;
    r.error_code   = err;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/iiad_ram.sv
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module iiad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: design/indexed_item_array_decoder.sv
// Indexed item array decoder: parses a blob byte by byte into header, descriptors and data.
// The slave-side stream carries one blob byte per transaction together with the blob length
// (sampled on the first byte) and tlast on the final byte. The master-side stream carries
// results: tuser holds the kind, tlast marks the final data byte of an item.
// Configuration writes (index 0 format tag, index 1 minimum size) go over the cfg channel,
// which is always ready; they must be made while the block is idle, which the block itself
// does not enforce. Each byte is captured in the idle state and then executed; in the data
// area the sequencer reads the offset table through one RAM port: it reads the end offset
// of each item it looks at, steps over empty or finished items and then fetches the begin
// offset and id. Results then go out on the master side, at most two results per byte.
// The block takes no byte while it works on one or while results wait; a stalled receiver
// therefore holds the slave side off. Reset returns to the start of a blob with the format
// tag at 0 and the minimum size at 24; the id and offset tables need no clearing.
`default_nettype none
module indexed_item_array_decoder #(
  parameter int MAX_ITEMS   = 255,
  parameter int LENGTH_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tdata: data_byte [7:0], total_length [31:8]
  input  wire logic [iiad_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  wire logic                          s_axis_tvalid,
  input  wire logic                          s_axis_tlast,
  output logic                               s_axis_tready,
  // tdata: item_index [7:0], item_id [39:8], word [71:40], length [95:72],
  //        payload_byte [103:96], error_code [105:104], zeros above
  output logic [iiad_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // tuser: kind [2:0]
  output logic [2:0]                         m_axis_tuser,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  output logic                               cfg_ready_o
);
  import iiad_pkg::*;

  localparam int AW = (MAX_ITEMS < 2) ? 1 : $clog2(MAX_ITEMS + 1);
  localparam int LB = LENGTH_BITS;
  localparam int XW = 34;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DHI, ST_DHIW, ST_DLOW, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_HEADER, PH_TABLE, PH_DATA, PH_DRAIN
  } phase_e;

  state_e      st_q, st_d;
  phase_e      phase_q, phase_d;
  logic [LB-1:0] bp_q, bp_d;
  logic [31:0] ws_q, ws_d;
  logic [LB-1:0] blen_q, blen_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [LB-1:0] prev_off_q, prev_off_d;
  logic [31:0] cur_id_q, cur_id_d;
  logic [31:0] last_id_q, last_id_d;
  logic [31:0] enc_q, enc_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [LB-1:0] hi_q, hi_d;
  logic [7:0]  byte_q, byte_d;
  logic [23:0] tl_q, tl_d;
  logic        last_q, last_d;
  logic [31:0] fmt_q;
  logic [4:0]  min_q;
  result_t     res_q [2];
  result_t     res_d [2];
  logic [1:0]  nres_q, nres_d;
  logic        oidx_q, oidx_d;

  // Table RAM ports.
  logic          id_we, off_we, id_re, off_re;
  logic [AW-1:0] id_waddr, off_waddr, id_raddr, off_raddr;
  logic [31:0]   id_wdata, id_rdata;
  logic [LB-1:0] off_wdata, off_rdata;

  iiad_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS + 1)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (id_waddr),
    .wdata_i (id_wdata),
    .re_i    (id_re),
    .raddr_i (id_raddr),
    .rdata_o (id_rdata)
  );

  iiad_ram #(.WIDTH(LB), .DEPTH(MAX_ITEMS + 1)) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (off_waddr),
    .wdata_i (off_wdata),
    .re_i    (off_re),
    .raddr_i (off_raddr),
    .rdata_o (off_rdata)
  );

  // Stream and configuration handshakes.
  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = (st_q == ST_OUT);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tuser  = res_q[oidx_q].kind;
  assign m_axis_tlast  = res_q[oidx_q].last_of_item;
  assign m_axis_tdata  = {6'd0, res_q[oidx_q].error_code, res_q[oidx_q].payload_byte,
                          res_q[oidx_q].length, res_q[oidx_q].word, res_q[oidx_q].item_id,
                          res_q[oidx_q].item_index};

  // Sequencer: executes one byte, then hands its results to the master side.
  always_comb begin
    phase_e      ph;
    logic [1:0]  n;
    result_t     rv [2];
    logic [31:0] ws_n;
    logic [XW-1:0] te_x, te_new, t_x, e_x, d_x, dsize_x, eff_x;
    logic        finish, data_fin, emit_ok;

    st_d       = st_q;
    phase_d    = phase_q;
    bp_d       = bp_q;
    ws_d       = ws_q;
    blen_d     = blen_q;
    cnt_d      = cnt_q;
    prev_off_d = prev_off_q;
    cur_id_d   = cur_id_q;
    last_id_d  = last_id_q;
    enc_d      = enc_q;
    cur_d      = cur_q;
    hi_d       = hi_q;
    byte_d     = byte_q;
    tl_d       = tl_q;
    last_d     = last_q;
    res_d[0]   = res_q[0];
    res_d[1]   = res_q[1];
    nres_d     = nres_q;
    oidx_d     = oidx_q;

    id_we     = 1'b0;
    off_we    = 1'b0;
    id_re     = 1'b0;
    off_re    = 1'b0;
    id_waddr  = '0;
    off_waddr = '0;
    id_raddr  = cur_q;
    off_raddr = cur_q;
    id_wdata  = ws_q;
    off_wdata = prev_off_q;

    ph       = phase_q;
    n        = 2'd0;
    rv[0]    = '0;
    rv[1]    = '0;
    finish   = 1'b0;
    data_fin = 1'b0;
    emit_ok  = 1'b0;
    ws_n     = {ws_q[23:0], byte_q};
    te_x     = XW'(HDR_BYTES) + ((XW'(cnt_q) + XW'(1)) << 3);
    te_new   = XW'(HDR_BYTES) + ((XW'(ws_n) + XW'(1)) << 3);
    t_x      = XW'(bp_q) - XW'(HDR_BYTES);
    e_x      = t_x >> 3;
    d_x      = XW'(bp_q) - te_x;
    dsize_x  = XW'(blen_q) - te_x;
    eff_x    = (min_q < 5'(MIN_FLOOR)) ? XW'(MIN_FLOOR) : XW'(min_q);

    case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          byte_d = s_axis_tdata[7:0];
          tl_d   = s_axis_tdata[31:8];
          last_d = s_axis_tlast;
          st_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (phase_q == PH_DATA) begin
          st_d = ST_DHI;
        end else begin
          finish = 1'b1;
          // Length check on the first byte of a blob.
          if (ph == PH_HEADER && bp_q == '0) begin
            blen_d = LB'(tl_q);
            if (XW'(blen_d) < eff_x) begin
              rv[n[0]] = make_result(KIND_ERROR, '0, '0, '0, '0, '0, 1'b0, ERR_TRUNC);
              n = n + 2'd1;
              ph = PH_DRAIN;
            end
          end
          if (ph == PH_HEADER) begin
            ws_d = ws_n;
            if (bp_q == LB'(3) && ws_n != fmt_q) begin
              rv[n[0]] = make_result(KIND_ERROR, '0, '0, '0, '0, '0, 1'b0, ERR_TAG);
              n = n + 2'd1;
              ph = PH_DRAIN;
            end else if (bp_q == LB'(11)) begin
              enc_d = ws_n;
            end else if (bp_q == LB'(15)) begin
              if (ws_n[31:24] != 8'd0 || XW'(ws_n) > XW'(MAX_ITEMS)) begin
                rv[n[0]] = make_result(KIND_ERROR, '0, '0, '0, '0, '0, 1'b0, ERR_COUNT);
                n = n + 2'd1;
                ph = PH_DRAIN;
              end else begin
                cnt_d = AW'(ws_n);
                if (te_new > XW'(blen_d)) begin
                  rv[n[0]] = make_result(KIND_ERROR, '0, '0, '0, '0, '0, 1'b0, ERR_TRUNC);
                  n = n + 2'd1;
                  ph = PH_DRAIN;
                end else begin
                  rv[n[0]] = make_result(KIND_HEADER, '0, '0, enc_q, 24'(ws_n), '0, 1'b0,
                                         ERR_TRUNC);
                  n = n + 2'd1;
                  prev_off_d = '0;
                  ph = PH_TABLE;
                end
              end
            end
            bp_d = LB'(XW'(bp_q) + XW'(1));
          end else if (ph == PH_TABLE) begin
            ws_d = ws_n;
            if (e_x <= XW'(cnt_q)) begin
              if (t_x[2:0] == 3'd3) begin
                id_we    = 1'b1;
                id_waddr = AW'(e_x);
                id_wdata = ws_n;
                cur_id_d = ws_n;
              end else if (t_x[2:0] == 3'd7) begin
                if (XW'(ws_n) < XW'(prev_off_q) || XW'(ws_n) > dsize_x) begin
                  rv[n[0]] = make_result(KIND_ERROR, '0, '0, '0, '0, '0, 1'b0, ERR_OFFSET);
                  n = n + 2'd1;
                  ph = PH_DRAIN;
                end else begin
                  off_we    = 1'b1;
                  off_waddr = AW'(e_x);
                  off_wdata = LB'(ws_n);
                  if (e_x != '0) begin
                    rv[n[0]] = make_result(KIND_DESC, 8'(e_x - XW'(1)), last_id_q,
                                           32'(prev_off_q), 24'(ws_n - 32'(prev_off_q)),
                                           '0, 1'b0, ERR_TRUNC);
                    n = n + 2'd1;
                  end
                  last_id_d  = cur_id_q;
                  prev_off_d = LB'(ws_n);
                  if (e_x == XW'(cnt_q)) begin
                    cur_d = '0;
                    ph = PH_DATA;
                    if (XW'(bp_q) + XW'(1) == XW'(blen_q)) begin
                      rv[n[0]] = make_result(KIND_DONE, '0, '0, '0, '0, '0, 1'b0, ERR_TRUNC);
                      n = n + 2'd1;
                      ph = PH_DRAIN;
                    end
                  end
                end
              end
            end
            bp_d = LB'(XW'(bp_q) + XW'(1));
          end
        end
      end
      // Look at the end offset of the current item.
      ST_DHI: begin
        if (cur_q < cnt_q) begin
          off_re    = 1'b1;
          off_raddr = AW'(XW'(cur_q) + XW'(1));
          st_d      = ST_DHIW;
        end else begin
          data_fin = 1'b1;
        end
      end
      // Step past finished or empty items, else fetch the begin offset and id.
      ST_DHIW: begin
        if (XW'(off_rdata) <= d_x) begin
          cur_d = AW'(XW'(cur_q) + XW'(1));
          st_d  = ST_DHI;
        end else begin
          hi_d   = off_rdata;
          off_re = 1'b1;
          id_re  = 1'b1;
          st_d   = ST_DLOW;
        end
      end
      ST_DLOW: begin
        data_fin = 1'b1;
        emit_ok  = (d_x >= XW'(off_rdata));
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          if (XW'(oidx_q) + XW'(1) >= XW'(nres_q)) begin
            st_d   = ST_IDLE;
            oidx_d = 1'b0;
          end else begin
            oidx_d = 1'b1;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    // End of a data byte: the tagged byte, then done on the final byte.
    if (data_fin) begin
      finish = 1'b1;
      if (emit_ok) begin
        rv[n[0]] = make_result(KIND_DATA, 8'(cur_q), id_rdata, '0, '0, byte_q,
                               (d_x + XW'(1) == XW'(hi_q)), ERR_TRUNC);
        n = n + 2'd1;
      end
      if (XW'(bp_q) + XW'(1) >= XW'(blen_q)) begin
        rv[n[0]] = make_result(KIND_DONE, '0, '0, '0, '0, '0, 1'b0, ERR_TRUNC);
        n = n + 2'd1;
        ph = PH_DRAIN;
      end
      bp_d = LB'(XW'(bp_q) + XW'(1));
    end

    // Close the byte: early end of blob, restart, and hand over results.
    if (finish) begin
      if (last_q) begin
        if (ph != PH_DRAIN) begin
          rv[n[0]] = make_result(KIND_ERROR, '0, '0, '0, '0, '0, 1'b0, ERR_TRUNC);
          n = n + 2'd1;
        end
        bp_d       = '0;
        ws_d       = '0;
        prev_off_d = '0;
        cur_d      = '0;
        ph         = PH_HEADER;
      end
      phase_d  = ph;
      res_d[0] = rv[0];
      res_d[1] = rv[1];
      nres_d   = n;
      oidx_d   = 1'b0;
      st_d     = (n == 2'd0) ? ST_IDLE : ST_OUT;
    end
  end

  // State, control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      phase_q    <= PH_HEADER;
      bp_q       <= '0;
      ws_q       <= '0;
      blen_q     <= '0;
      cnt_q      <= '0;
      prev_off_q <= '0;
      enc_q      <= '0;
      cur_q      <= '0;
      nres_q     <= '0;
      oidx_q     <= 1'b0;
      fmt_q      <= '0;
      min_q      <= 5'd24;
    end else begin
      st_q       <= st_d;
      phase_q    <= phase_d;
      bp_q       <= bp_d;
      ws_q       <= ws_d;
      blen_q     <= blen_d;
      cnt_q      <= cnt_d;
      prev_off_q <= prev_off_d;
      enc_q      <= enc_d;
      cur_q      <= cur_d;
      nres_q     <= nres_d;
      oidx_q     <= oidx_d;
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FORMAT_TAG: fmt_q <= cfg_data_i;
          CFG_MIN_SIZE:   min_q <= cfg_data_i[4:0];
          default:        fmt_q <= fmt_q;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_id_q  <= cur_id_d;
    last_id_q <= last_id_d;
    hi_q      <= hi_d;
    byte_q    <= byte_d;
    tl_q      <= tl_d;
    last_q    <= last_d;
    res_q[0]  <= res_d[0];
    res_q[1]  <= res_d[1];
  end

endmodule
`default_nettype wire
